[rtl/cfr_pkg.sv]
// Package for the command frame receiver: frame byte codes, status and
// decode codes, the result record and the byte decode functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 255;

  localparam logic [7:0] START_BYTE = 8'h4B;  // 'K'
  localparam logic [7:0] END_BYTE   = 8'h53;  // 'S'
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  localparam logic [7:0] DIR_DIGIT_LO   = 8'h30;  // '0'
  localparam logic [7:0] DIR_DIGIT_HI   = 8'h34;  // '4'
  localparam logic [7:0] SPEED_DIGIT_LO = 8'h31;  // '1'
  localparam logic [7:0] SPEED_DIGIT_HI = 8'h33;  // '3'

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [2:0] DIR_UNCHANGED = 3'd5;
  localparam logic [1:0] SPEED_KEEP    = 2'd0;

  typedef struct packed {
    logic [1:0] frame_status;
    logic [2:0] direction_code;
    logic [1:0] speed_level;
    logic [7:0] servo_byte;
  } cfr_result_t;

  function automatic logic [2:0] decode_direction(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - DIR_DIGIT_LO;
    if (b >= DIR_DIGIT_LO && b <= DIR_DIGIT_HI) begin
      return diff[2:0];
    end
    return DIR_UNCHANGED;
  endfunction

  function automatic logic [1:0] decode_speed(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - DIR_DIGIT_LO;
    if (b >= SPEED_DIGIT_LO && b <= SPEED_DIGIT_HI) begin
      return diff[1:0];
    end
    return SPEED_KEEP;
  endfunction

  // 8-bit sum with the carry folded back in (one's complement add).
  function automatic logic [7:0] add_eac(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

`default_nettype wire

[rtl/cfr_in_reg.sv]
// Input register of the command frame receiver: holds one received byte
// until the frame tracker consumes it. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module cfr_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       advance_i,
  output logic            byte_valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // The stage frees up in the same cycle the tracker consumes its byte.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

`default_nettype wire

[rtl/cfr_frame_track.sv]
// Frame tracker: holds the frame state (open flag, count, running sum,
// captured bytes, overflow) and forms the result when 'S' closes a frame.
// Depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfr_frame_track #(
  parameter int unsigned MaxFrameBytes = cfr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output logic                     res_valid_o,
  output cfr_pkg::cfr_result_t     res_o
);

  import cfr_pkg::*;

  localparam logic [7:0] MaxCount = 8'(MaxFrameBytes);

  logic       in_frame_q, in_frame_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic       ovf_q, ovf_d;
  logic [7:0] cap_q [3];
  logic [7:0] cap_d [3];
  logic       active;
  logic       close;

  always_comb begin
    active = in_frame_q || (byte_i == START_BYTE);
    close  = step_i && active && (byte_i == END_BYTE);

    in_frame_d = in_frame_q;
    count_d    = count_q;
    sum_d      = sum_q;
    ovf_d      = ovf_q;
    for (int i = 0; i < 3; i++) begin
      cap_d[i] = cap_q[i];
    end

    if (step_i && active) begin
      in_frame_d = 1'b1;
      if (count_q >= MaxCount) begin
        ovf_d = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (count_q == 8'(i + 1)) begin
            cap_d[i] = byte_i;
          end
        end
        count_d = count_q + 8'd1;
      end
      sum_d = add_eac(sum_q, byte_i);
    end

    // The result is taken from the updated state, so an 'S' that lands
    // at a captured position is seen in the decode.
    res_valid_o = close;
    if (ovf_d) begin
      res_o.frame_status = STATUS_TOO_LONG;
    end else if (sum_d != SUM_GOOD) begin
      res_o.frame_status = STATUS_BAD_SUM;
    end else begin
      res_o.frame_status = STATUS_OK;
    end
    if (res_o.frame_status == STATUS_OK) begin
      res_o.direction_code = decode_direction(cap_d[0]);
      res_o.speed_level    = decode_speed(cap_d[1]);
      res_o.servo_byte     = cap_d[2];
    end else begin
      res_o.direction_code = DIR_UNCHANGED;
      res_o.speed_level    = SPEED_KEEP;
      res_o.servo_byte     = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= 8'd0;
      sum_q      <= 8'd0;
      ovf_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cap_q[i] <= 8'd0;
      end
    end else if (close) begin
      in_frame_q <= 1'b0;
      count_q    <= 8'd0;
      sum_q      <= 8'd0;
      ovf_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cap_q[i] <= 8'd0;
      end
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      ovf_q      <= ovf_d;
      for (int i = 0; i < 3; i++) begin
        cap_q[i] <= cap_d[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/cfr_out_reg.sv]
// Result register of the command frame receiver: holds one finished
// result until the consumer takes it. Depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfr_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire cfr_pkg::cfr_result_t res_i,
  output logic                      advance_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output cfr_pkg::cfr_result_t      res_o
);

  import cfr_pkg::*;

  logic        valid_q, valid_d;
  cfr_result_t res_q;

  // The upstream stage may move whenever this register is empty or drains.
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[rtl/command_frame_receiver_top.sv]
// Top level of the command frame receiver.
// Depends on cfr_pkg, cfr_in_reg, cfr_frame_track and cfr_out_reg.
//
// Usage:
//   Bytes enter on the rx channel (rx_byte_i with rx_valid_i/rx_ready_o),
//   one transfer per byte. Outside a frame every byte but 'K' is dropped.
//   'K' opens a frame, 'S' closes it, and each closed frame yields one
//   transfer on the result channel (res_valid_o/res_ready_i) carrying
//   frame_status_o, direction_code_o, speed_level_o and servo_byte_o.
//   Bytes that do not close a frame produce no result.
//
//   The closing byte enters the input register at its transfer, and its
//   result enters the result register when that register can load.
//   Throughput: one byte per cycle unless a waiting result stalls; the
//   per-byte work is a single end-around-carry add and a few compares.
//
//   Reset: all frame state clears, both registers empty, no frame open.
//   Stall: while a result waits for res_ready_i the input register still
//   accepts one byte; further bytes are held off with rx_ready_o low until
//   the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver_top #(
  parameter int unsigned MaxFrameBytes = cfr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [1:0]      frame_status_o,
  output logic [2:0]      direction_code_o,
  output logic [1:0]      speed_level_o,
  output logic [7:0]      servo_byte_o
);

  import cfr_pkg::*;

  logic        advance;
  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        res_valid;
  cfr_result_t res_next;
  cfr_result_t res_out;

  cfr_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_valid_i),
    .in_ready_o  (rx_ready_o),
    .in_byte_i   (rx_byte_i),
    .advance_i   (advance),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_q)
  );

  cfr_frame_track #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_frame_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (byte_valid && advance),
    .byte_i     (byte_q),
    .res_valid_o(res_valid),
    .res_o      (res_next)
  );

  cfr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res_next),
    .advance_o  (advance),
    .out_valid_o(res_valid_o),
    .out_ready_i(res_ready_i),
    .res_o      (res_out)
  );

  assign frame_status_o   = res_out.frame_status;
  assign direction_code_o = res_out.direction_code;
  assign speed_level_o    = res_out.speed_level;
  assign servo_byte_o     = res_out.servo_byte;

endmodule

`default_nettype wire
